@@ rtl/core/seven_segment_digit_buffer_scan_unit_assert.svh @@
// ----------------------------------------------------------------------------
// assertion macros for the display scan unit
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_DIGIT_BUFFER_SCAN_UNIT_ASSERT_SVH
`define SEVEN_SEGMENT_DIGIT_BUFFER_SCAN_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define SSD_ASSERT_NOW(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define SSD_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ rtl/core/ssd_pkg.sv @@
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types, codes, segment tables and helpers of the display scan unit.
// ----------------------------------------------------------------------------
package ssd_pkg;

  // request codes
  typedef enum logic [2:0] {
    REQ_PUSH  = 3'd0,
    REQ_POP   = 3'd1,
    REQ_CLEAR = 3'd2,
    REQ_LOAD  = 3'd3,
    REQ_READ  = 3'd4,
    REQ_ERROR = 3'd5,
    REQ_SCAN  = 3'd6
  } ssd_req_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOAD,
    ST_READ,
    ST_FINISH
  } ssd_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic load_step;
    logic read_step;
    logic finish;
  } ssd_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    ssd_req_t req;
    logic     empty;
    logic     load_none;
    logic     load_last;
    logic     read_last;
  } ssd_sts_t;

  localparam logic [7:0] SEG_ALL_OFF = 8'hFF;
  localparam logic [7:0] SEG_ALL_ON  = 8'h00;
  localparam logic [7:0] SEL_ALL_OFF = 8'hFF;

  localparam logic [6:0] CODE_DIGIT_END = 7'd10;
  localparam logic [6:0] CODE_A        = 7'd65;
  localparam logic [6:0] CODE_Z        = 7'd90;
  localparam logic [6:0] CODE_E        = 7'd69;
  localparam logic [6:0] CODE_R        = 7'd82;

  localparam int         ERR_LEN = 3;
  localparam logic [6:0] ERR_TEXT [ERR_LEN] = '{CODE_E, CODE_R, CODE_R};

  // two board positions whose select lines are wired crossed
  localparam logic [2:0] SWAP_LO = 3'd5;
  localparam logic [2:0] SWAP_HI = 3'd6;

  // divide by ten through a reciprocal, exact for every 32-bit value
  localparam logic [31:0] RECIP_DIV10 = 32'hCCCCCCCD;
  localparam int          RECIP_SHIFT = 35;

  localparam int MAX_DIGITS = 10;

  localparam logic [31:0] POW10 [MAX_DIGITS] = '{
    32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
    32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000
  };

  localparam logic [7:0] DIGIT_SEGS [10] = '{
    8'h88, 8'hF9, 8'h4C, 8'h68, 8'h39, 8'h2A, 8'h0A, 8'hF8, 8'h08, 8'h28
  };

  localparam logic [7:0] LETTER_SEGS [26] = '{
    8'hEF, 8'hFC, 8'h79, 8'hBE, 8'h0E, 8'hE9, 8'hDF, 8'hEC, 8'hFB, 8'h3E,
    8'hEE, 8'h8F, 8'hDA, 8'h5B, 8'h4B, 8'h1C, 8'h38, 8'h5F, 8'hDD, 8'h0F,
    8'h89, 8'hCB, 8'hAD, 8'h19, 8'h29, 8'h4C
  };

  // segment pattern of a symbol code, unknown codes light every segment
  function automatic logic [7:0] ssd_pattern(input logic [6:0] code);
    logic [6:0] ofs;
    ofs = code - CODE_A;
    if (code < CODE_DIGIT_END) begin
      return DIGIT_SEGS[code[3:0]];
    end else if (code >= CODE_A && code <= CODE_Z) begin
      return LETTER_SEGS[ofs[4:0]];
    end else begin
      return SEG_ALL_ON;
    end
  endfunction

  // number of decimal digits of a value, zero for zero
  function automatic logic [3:0] ssd_digit_len(input logic [31:0] v);
    logic [3:0] len;
    len = 4'd0;
    for (int j = 0; j < MAX_DIGITS; j++) begin
      if (v >= POW10[j]) len = len + 4'd1;
    end
    return len;
  endfunction

endpackage

@@ rtl/core/ssd_in_if.sv @@
// ----------------------------------------------------------------------------
// ssd_in_if
// Request channel: valid/ready handshake with request payload.
// ----------------------------------------------------------------------------
interface ssd_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic [6:0]         symbol;
  logic signed [31:0] number_in;

  modport source (output valid, output req_type, output symbol, output number_in,
                  input ready);
  modport sink   (input valid, input req_type, input symbol, input number_in,
                  output ready);
endinterface

@@ rtl/core/ssd_out_if.sv @@
// ----------------------------------------------------------------------------
// ssd_out_if
// Result channel: valid/ready handshake with display and buffer status.
// ----------------------------------------------------------------------------
interface ssd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  seg_pattern;
  logic [7:0]  digit_select;
  logic [31:0] number_out;
  logic [3:0]  digit_count;
  logic        rejected;

  modport source (output valid, output seg_pattern, output digit_select,
                  output number_out, output digit_count, output rejected,
                  input ready);
  modport sink   (input valid, input seg_pattern, input digit_select,
                  input number_out, input digit_count, input rejected,
                  output ready);
endinterface

@@ rtl/core/seven_segment_digit_buffer_scan_unit.sv @@
// Each accepted request runs an exec step, then one step per decimal digit for load
//   (digits kept) and read (symbols held), then a finish step that waits for the result.
// No new request is taken until the last one is through; the digit
//   split (reciprocal divide by ten) and the multiply-accumulate take one digit a cycle.
// Reset: buffer empty, scan index zero, both latches all ones; symbol store undefined.
// ----------------------------------------------------------------------------
// seven_segment_digit_buffer_scan_unit
// Multiplexed seven-segment display controller with a decimal symbol buffer.
// ----------------------------------------------------------------------------
module seven_segment_digit_buffer_scan_unit #(
  parameter int BUFFER_DEPTH    = 10,
  parameter int DIGIT_POSITIONS = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  ssd_in_if.sink       in_ch,
  ssd_out_if.source    out_ch
);
  import ssd_pkg::*;

  ssd_cmd_t cmd;
  ssd_sts_t sts;

  // sequencer
  ssd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // buffer, latches and arithmetic
  ssd_dp #(
    .BUFFER_DEPTH    (BUFFER_DEPTH),
    .DIGIT_POSITIONS (DIGIT_POSITIONS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .req_type     (in_ch.req_type),
    .symbol       (in_ch.symbol),
    .number_in    (in_ch.number_in),
    .seg_pattern  (out_ch.seg_pattern),
    .digit_select (out_ch.digit_select),
    .number_out   (out_ch.number_out),
    .digit_count  (out_ch.digit_count),
    .rejected     (out_ch.rejected)
  );

endmodule

@@ rtl/core/ssd_ctrl.sv @@
// ----------------------------------------------------------------------------
// ssd_ctrl
// Request sequencer: accepts a beat, runs the operation, hands off the result.
// ----------------------------------------------------------------------------
module ssd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ssd_pkg::ssd_sts_t sts,
  output ssd_pkg::ssd_cmd_t cmd
);
  import ssd_pkg::*;

  `include "seven_segment_digit_buffer_scan_unit_assert.svh"

  ssd_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // state and result-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.req == REQ_LOAD && !sts.load_none) begin
          state_nxt = ST_LOAD;
        end else if (sts.req == REQ_READ && !sts.empty) begin
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_LOAD: begin
        cmd.load_step = 1'b1;
        if (sts.load_last) state_nxt = ST_FINISH;
      end
      ST_READ: begin
        cmd.read_step = 1'b1;
        if (sts.read_last) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  // checks
  `SSD_ASSERT_NEXT(a_accept_to_exec, clk, rst_n, in_valid && in_ready, state_r == ST_EXEC)
  `SSD_ASSERT_NEXT(a_finish_shows_result, clk, rst_n, cmd.finish, out_valid_r)
  `SSD_ASSERT_NOW(a_load_state_req, clk, rst_n, state_r == ST_LOAD, sts.req == REQ_LOAD)

endmodule

@@ rtl/core/ssd_dp.sv @@
// ----------------------------------------------------------------------------
// ssd_dp
// Datapath: symbol buffer, display latches, digit split and accumulate unit.
// ----------------------------------------------------------------------------
module ssd_dp #(
  parameter int BUFFER_DEPTH    = 10,
  parameter int DIGIT_POSITIONS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ssd_pkg::ssd_cmd_t  cmd,
  output ssd_pkg::ssd_sts_t  sts,
  input  logic [2:0]         req_type,
  input  logic [6:0]         symbol,
  input  logic signed [31:0] number_in,
  output logic [7:0]         seg_pattern,
  output logic [7:0]         digit_select,
  output logic [31:0]        number_out,
  output logic [3:0]         digit_count,
  output logic               rejected
);
  import ssd_pkg::*;

  `include "seven_segment_digit_buffer_scan_unit_assert.svh"

  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
  localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(BUFFER_DEPTH);
  localparam logic [CNT_W-1:0] ERR_FILL =
    CNT_W'((BUFFER_DEPTH < ERR_LEN) ? BUFFER_DEPTH : ERR_LEN);

  // request registers
  ssd_req_t          req_r, req_nxt;
  logic [6:0]        sym_r, sym_nxt;
  logic [31:0]       num_r, num_nxt;

  // buffer and display state
  logic [6:0]        store_r [BUFFER_DEPTH];
  logic [6:0]        store_nxt [BUFFER_DEPTH];
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [IDX_W-1:0]  scan_r, scan_nxt;
  logic [7:0]        seg_r, seg_nxt;
  logic [7:0]        sel_r, sel_nxt;
  logic              rej_r, rej_nxt;

  // digit split and accumulate
  logic [31:0]       val_r, val_nxt;
  logic [31:0]       acc_r, acc_nxt;
  logic [IDX_W-1:0]  widx_r, widx_nxt;
  logic [IDX_W-1:0]  ridx_r, ridx_nxt;

  // output register
  logic [7:0]        oseg_r, oseg_nxt;
  logic [7:0]        osel_r, osel_nxt;
  logic [31:0]       onum_r, onum_nxt;
  logic [3:0]        ocnt_r, ocnt_nxt;
  logic              orej_r, orej_nxt;

  // helpers
  logic [63:0]       prod;
  logic [31:0]       quot;
  logic [31:0]       rem;
  logic [4:0]        len5;
  logic [CNT_W-1:0]  keep;
  logic              load_none;
  logic [IDX_W-1:0]  sidx;
  logic [CNT_W-1:0]  sidx_inc;
  logic [CNT_W-1:0]  pos;
  logic [4:0]        pos5;
  logic [2:0]        bitp;
  logic [4:0]        cnt5;

  // one decimal digit off the working value
  assign prod = 64'(val_r) * 64'(RECIP_DIV10);
  assign quot = 32'(prod >> RECIP_SHIFT);
  assign rem  = val_r - ((quot << 3) + (quot << 1));

  // digits kept by a load, lowest ones win
  assign len5      = 5'(ssd_digit_len(num_r));
  assign keep      = (len5 > 5'(BUFFER_DEPTH)) ? DEPTH_C : CNT_W'(len5);
  assign load_none = (num_r == 32'd0) || num_r[31];

  // scan position of the next shown entry
  assign sidx     = (CNT_W'(scan_r) >= fill_r) ? '0 : scan_r;
  assign sidx_inc = CNT_W'(sidx) + CNT_W'(1);
  assign pos      = fill_r - CNT_W'(1) - CNT_W'(sidx);
  assign pos5     = 5'(pos);
  assign cnt5     = 5'(fill_r);

  // crossed positions swap select lines
  always_comb begin
    bitp = pos5[2:0];
    if (pos5[2:0] == SWAP_LO) bitp = SWAP_HI;
    else if (pos5[2:0] == SWAP_HI) bitp = SWAP_LO;
  end

  // status to controller
  assign sts.req       = req_r;
  assign sts.empty     = (fill_r == '0);
  assign sts.load_none = load_none;
  assign sts.load_last = (widx_r == '0);
  assign sts.read_last = (CNT_W'(ridx_r) == fill_r - CNT_W'(1));

  // next-state logic
  always_comb begin
    req_nxt   = req_r;
    sym_nxt   = sym_r;
    num_nxt   = num_r;
    store_nxt = store_r;
    fill_nxt  = fill_r;
    scan_nxt  = scan_r;
    seg_nxt   = seg_r;
    sel_nxt   = sel_r;
    rej_nxt   = rej_r;
    val_nxt   = val_r;
    acc_nxt   = acc_r;
    widx_nxt  = widx_r;
    ridx_nxt  = ridx_r;
    oseg_nxt  = oseg_r;
    osel_nxt  = osel_r;
    onum_nxt  = onum_r;
    ocnt_nxt  = ocnt_r;
    orej_nxt  = orej_r;

    // capture accepted beat
    if (cmd.capture) begin
      req_nxt = ssd_req_t'(req_type);
      sym_nxt = symbol;
      num_nxt = 32'(number_in);
    end

    // exec step of each request
    if (cmd.exec) begin
      acc_nxt = '0;
      rej_nxt = 1'b0;
      case (req_r)
        REQ_PUSH: begin
          if (fill_r >= DEPTH_C) begin
            rej_nxt = 1'b1;
          end else begin
            store_nxt[fill_r[IDX_W-1:0]] = sym_r;
            fill_nxt = fill_r + CNT_W'(1);
          end
        end
        REQ_POP: begin
          if (fill_r == CNT_W'(1)) begin
            fill_nxt = '0;
            scan_nxt = '0;
            sel_nxt  = SEL_ALL_OFF;
          end else if (fill_r > CNT_W'(1)) begin
            fill_nxt = fill_r - CNT_W'(1);
          end
        end
        REQ_CLEAR: begin
          fill_nxt = '0;
          scan_nxt = '0;
          sel_nxt  = SEL_ALL_OFF;
        end
        REQ_LOAD: begin
          scan_nxt = '0;
          sel_nxt  = SEL_ALL_OFF;
          if (load_none) begin
            fill_nxt = '0;
          end else begin
            fill_nxt = keep;
            widx_nxt = IDX_W'(keep - CNT_W'(1));
            val_nxt  = num_r;
          end
        end
        REQ_READ: begin
          ridx_nxt = '0;
          if (fill_r == '0) begin
            scan_nxt = '0;
            sel_nxt  = SEL_ALL_OFF;
          end
        end
        REQ_ERROR: begin
          scan_nxt = '0;
          sel_nxt  = SEL_ALL_OFF;
          fill_nxt = ERR_FILL;
          for (int i = 0; i < BUFFER_DEPTH; i++) begin
            if (i < ERR_LEN) store_nxt[i] = ERR_TEXT[i];
          end
        end
        REQ_SCAN: begin
          if (fill_r != '0) begin
            seg_nxt = ssd_pattern(store_r[sidx]);
            if (pos5 >= 5'(DIGIT_POSITIONS)) sel_nxt = SEL_ALL_OFF;
            else sel_nxt = ~(8'd1 << bitp);
            scan_nxt = (sidx_inc >= fill_r) ? '0 : IDX_W'(sidx_inc);
          end
        end
        default: begin
        end
      endcase
    end

    // load: one digit per cycle, most significant entry last
    if (cmd.load_step) begin
      store_nxt[widx_r] = {3'b000, rem[3:0]};
      val_nxt           = quot;
      widx_nxt          = widx_r - IDX_W'(1);
    end

    // read: value = value * 10 + code, then empty the buffer
    if (cmd.read_step) begin
      acc_nxt  = (acc_r << 3) + (acc_r << 1) + 32'(store_r[ridx_r]);
      ridx_nxt = ridx_r + IDX_W'(1);
      if (sts.read_last) begin
        fill_nxt = '0;
        scan_nxt = '0;
        sel_nxt  = SEL_ALL_OFF;
      end
    end

    // result snapshot
    if (cmd.finish) begin
      oseg_nxt = seg_r;
      osel_nxt = sel_r;
      onum_nxt = acc_r;
      ocnt_nxt = cnt5[3:0];
      orej_nxt = rej_r;
    end
  end

  // control state and latches
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      scan_r <= '0;
      seg_r  <= SEG_ALL_OFF;
      sel_r  <= SEL_ALL_OFF;
    end else begin
      fill_r <= fill_nxt;
      scan_r <= scan_nxt;
      seg_r  <= seg_nxt;
      sel_r  <= sel_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    sym_r   <= sym_nxt;
    num_r   <= num_nxt;
    store_r <= store_nxt;
    rej_r   <= rej_nxt;
    val_r   <= val_nxt;
    acc_r   <= acc_nxt;
    widx_r  <= widx_nxt;
    ridx_r  <= ridx_nxt;
    oseg_r  <= oseg_nxt;
    osel_r  <= osel_nxt;
    onum_r  <= onum_nxt;
    ocnt_r  <= ocnt_nxt;
    orej_r  <= orej_nxt;
  end

  assign seg_pattern  = oseg_r;
  assign digit_select = osel_r;
  assign number_out   = onum_r;
  assign digit_count  = ocnt_r;
  assign rejected     = orej_r;

  // checks
  `SSD_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1, fill_r <= DEPTH_C)
  `SSD_ASSERT_NOW(a_read_in_range, clk, rst_n, cmd.read_step, CNT_W'(ridx_r) < fill_r)

endmodule

@@ tb/sv/seven_segment_digit_buffer_scan_unit_tb.sv @@
// ----------------------------------------------------------------------------
// seven_segment_digit_buffer_scan_unit_tb
// Self-checking bench for the display scan unit. A queue of request beats
// (a directed opening, then weighted random traffic) feeds a clocked driver.
// The driver runs each accepted beat through a local model of the symbol
// buffer and the display latches. A clocked monitor compares every result
// beat field by field with the oldest prediction. Both sides idle at random,
// the receiver once holds off long enough to back up the input, and the
// sender twice waits for the result queue to drain.
// ----------------------------------------------------------------------------
module seven_segment_digit_buffer_scan_unit_tb;
  import ssd_pkg::*;

  localparam int STORE_DEPTH     = 10;
  localparam int SHOWN_POSITIONS = 8;
  localparam int RANDOM_BEATS    = 1200;
  localparam int SETTLE_CYCLES   = 20;
  localparam int HOLD_CYCLES     = 400;
  localparam int HOLD_AFTER      = 300;
  localparam longint LIMIT_CYCLES = 800_000;

  // request code with no operation behind it
  localparam logic [2:0] REQ_NOP = 3'd7;

  // active-low glyphs, independent of the design tables
  localparam logic [7:0] GLYPH_DIGIT [10] = '{
    8'h88, 8'hF9, 8'h4C, 8'h68, 8'h39, 8'h2A, 8'h0A, 8'hF8, 8'h08, 8'h28
  };
  localparam logic [7:0] GLYPH_LETTER [26] = '{
    8'hEF, 8'hFC, 8'h79, 8'hBE, 8'h0E, 8'hE9, 8'hDF, 8'hEC, 8'hFB, 8'h3E,
    8'hEE, 8'h8F, 8'hDA, 8'h5B, 8'h4B, 8'h1C, 8'h38, 8'h5F, 8'hDD, 8'h0F,
    8'h89, 8'hCB, 8'hAD, 8'h19, 8'h29, 8'h4C
  };

  typedef struct {
    logic [2:0]         req;
    logic [6:0]         sym;
    logic signed [31:0] num;
    bit                 drain;
  } disp_req_t;

  typedef struct {
    logic [7:0]  seg;
    logic [7:0]  sel;
    logic [31:0] value;
    logic [3:0]  count;
    logic        rej;
  } disp_res_t;

  logic clk = 1'b0;
  logic rst_n;
  logic rx_hold;

  ssd_in_if  in_ch();
  ssd_out_if out_ch();

  seven_segment_digit_buffer_scan_unit #(
    .BUFFER_DEPTH    (STORE_DEPTH),
    .DIGIT_POSITIONS (SHOWN_POSITIONS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // display model state
  logic [6:0] sym_store [16];
  int         fill_cnt = 0;
  int         scan_idx = 0;
  logic [7:0] seg_now = 8'hFF;
  logic [7:0] sel_now = 8'hFF;

  disp_req_t req_q[$];
  disp_res_t display_q[$];
  disp_req_t on_wire;
  int        beats_total;
  int        beats_sent = 0;
  int        results_seen = 0;
  int        fails = 0;
  int        tx_gap;
  int        rx_stall;
  bit        tx_calm = 1'b0;
  bit        rx_calm = 1'b0;

  always #5 clk = ~clk;

  function automatic logic [7:0] glyph_of(input logic [6:0] code);
    logic [6:0] ofs;
    ofs = code - CODE_A;
    if (code < 7'd10) return GLYPH_DIGIT[code[3:0]];
    if (code >= CODE_A && code <= CODE_Z) return GLYPH_LETTER[ofs[4:0]];
    return 8'h00;
  endfunction

  function automatic void blank_buffer();
    fill_cnt = 0;
    scan_idx = 0;
    sel_now  = 8'hFF;
  endfunction

  function automatic bit store_symbol(input logic [6:0] code);
    if (fill_cnt >= STORE_DEPTH) return 1'b0;
    sym_store[fill_cnt] = code;
    fill_cnt++;
    return 1'b1;
  endfunction

  // next state of the display for one request beat, and its result
  function automatic disp_res_t step_display(input disp_req_t q);
    disp_res_t  r;
    logic [31:0] v;
    logic [6:0]  digs [10];
    int          n;
    int          keep;
    int          pos;
    int          bit_no;
    r.value = 32'd0;
    r.rej   = 1'b0;
    case (q.req)
      REQ_PUSH: r.rej = !store_symbol(q.sym);
      REQ_POP: begin
        if (fill_cnt == 1) blank_buffer();
        else if (fill_cnt > 1) fill_cnt--;
      end
      REQ_CLEAR: blank_buffer();
      REQ_LOAD: begin
        v = q.num;
        blank_buffer();
        if (v != 32'd0 && !v[31]) begin
          n = 0;
          while (v != 32'd0 && n < 10) begin
            digs[n] = 7'(v % 10);
            v = v / 10;
            n++;
          end
          keep = (n > STORE_DEPTH) ? STORE_DEPTH : n;
          for (int k = 0; k < keep; k++) sym_store[k] = digs[keep - 1 - k];
          fill_cnt = keep;
        end
      end
      REQ_READ: begin
        for (int k = 0; k < fill_cnt; k++) r.value = r.value * 10 + sym_store[k];
        blank_buffer();
      end
      REQ_ERROR: begin
        blank_buffer();
        void'(store_symbol(CODE_E));
        void'(store_symbol(CODE_R));
        void'(store_symbol(CODE_R));
      end
      REQ_SCAN: begin
        if (fill_cnt != 0) begin
          if (scan_idx >= fill_cnt) scan_idx = 0;
          seg_now = glyph_of(sym_store[scan_idx]);
          pos = fill_cnt - 1 - scan_idx;
          if (pos >= SHOWN_POSITIONS || pos >= 8) begin
            sel_now = 8'hFF;
          end else begin
            // two board positions have their select lines crossed
            bit_no = (pos == 5) ? 6 : (pos == 6) ? 5 : pos;
            sel_now = ~(8'd1 << bit_no);
          end
          scan_idx++;
          if (scan_idx >= fill_cnt) scan_idx = 0;
        end
      end
      default: ;
    endcase
    r.seg   = seg_now;
    r.sel   = sel_now;
    r.count = 4'(fill_cnt);
    return r;
  endfunction

  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [6:0] pick_symbol();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 7'($urandom_range(0, 9));
    if (r < 90) return 7'($urandom_range(CODE_A, CODE_Z));
    return 7'($urandom_range(0, 127));
  endfunction

  // positive values spread over every digit length, plus zero and negatives
  function automatic logic signed [31:0] pick_load_value();
    int              r;
    int              len;
    longint unsigned lo;
    longint unsigned hi;
    r = $urandom_range(0, 99);
    if (r < 6) return 32'sd0;
    if (r < 14) return $urandom | 32'h8000_0000;
    if (r < 20) return $urandom;
    len = $urandom_range(1, 10);
    lo = 1;
    repeat (len - 1) lo = lo * 10;
    hi = lo * 10 - 1;
    if (hi > 64'h7FFF_FFFF) hi = 64'h7FFF_FFFF;
    return 32'(lo + ({$urandom, $urandom} % (hi - lo + 1)));
  endfunction

  function automatic void add_beat(input logic [2:0] req, input logic [6:0] sym,
                                   input logic signed [31:0] num, input bit drain);
    disp_req_t q;
    q.req   = req;
    q.sym   = sym;
    q.num   = num;
    q.drain = drain;
    req_q.insert(req_q.size(), q);
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
      fails++;
    end
  endfunction

  // request driver: presents queued beats, predicts each accepted one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.req_type  <= REQ_NOP;
      in_ch.symbol    <= 7'd0;
      in_ch.number_in <= 32'sd0;
      tx_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        display_q.insert(display_q.size(), step_display(on_wire));
        beats_sent++;
        if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
        tx_gap = pick_gap(tx_calm);
      end
      if (in_ch.valid && !in_ch.ready) begin
        // beat still offered, hold it
      end else if (tx_gap > 0) begin
        tx_gap--;
        in_ch.valid <= 1'b0;
      end else if (req_q.size() != 0 && !(req_q[0].drain && display_q.size() != 0)) begin
        on_wire = req_q.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.req_type  <= on_wire.req;
        in_ch.symbol    <= on_wire.sym;
        in_ch.number_in <= on_wire.num;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result monitor: random back-pressure and field compare
  always @(posedge clk) begin
    disp_res_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (display_q.size() == 0) begin
          $display("%0t: result beat expected none actual seg %0h sel %0h value %0h",
                   $time, out_ch.seg_pattern, out_ch.digit_select, out_ch.number_out);
          fails++;
        end else begin
          want = display_q.pop_front();
          check_field("seg_pattern", 32'(want.seg), 32'(out_ch.seg_pattern));
          check_field("digit_select", 32'(want.sel), 32'(out_ch.digit_select));
          check_field("number_out", want.value, out_ch.number_out);
          check_field("digit_count", 32'(want.count), 32'(out_ch.digit_count));
          check_field("rejected", 32'(want.rej), 32'(out_ch.rejected));
        end
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
      end
      if (rx_stall > 0) rx_stall--;
      else if ($urandom_range(0, 3) == 0) rx_stall = pick_gap(rx_calm);
      out_ch.ready <= !rx_hold && rx_stall == 0;
    end
  end

  // one long receiver hold-off mid-run so the input backs up
  initial begin
    rx_hold = 1'b0;
    wait (results_seen >= HOLD_AFTER);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // run limit
  initial begin
    #(LIMIT_CYCLES * 10);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // stimulus, reset and end of run
  initial begin
    int r;
    rst_n = 1'b0;

    // directed: empty buffer, unknown glyph, letters in a read, load corners
    add_beat(REQ_SCAN, 7'd0, 32'sd0, 1'b0);
    add_beat(REQ_POP, 7'd0, 32'sd0, 1'b0);
    add_beat(REQ_NOP, 7'd0, 32'sd0, 1'b0);
    add_beat(REQ_PUSH, 7'd0, 32'sd0, 1'b0);
    add_beat(REQ_PUSH, 7'd127, 32'sd0, 1'b0);
    add_beat(REQ_SCAN, 7'd0, 32'sd0, 1'b0);
    add_beat(REQ_SCAN, 7'd0, 32'sd0, 1'b0);
    add_beat(REQ_POP, 7'd0, 32'sd0, 1'b0);
    add_beat(REQ_POP, 7'd0, 32'sd0, 1'b0);
    add_beat(REQ_PUSH, CODE_Z, 32'sd0, 1'b0);
    add_beat(REQ_READ, 7'd0, 32'sd0, 1'b0);
    add_beat(REQ_LOAD, 7'd0, 32'sd0, 1'b0);
    add_beat(REQ_LOAD, 7'd0, -32'sd1, 1'b0);
    add_beat(REQ_LOAD, 7'd0, 32'sh8000_0000, 1'b0);
    add_beat(REQ_LOAD, 7'd0, 32'sh7FFF_FFFF, 1'b0);
    add_beat(REQ_PUSH, CODE_A, 32'sd0, 1'b0);
    // walk the high positions: blanks, a normal one, the crossed pair, then normal ones
    repeat (7) add_beat(REQ_SCAN, 7'd0, 32'sd0, 1'b0);
    add_beat(REQ_ERROR, 7'd0, 32'sd0, 1'b0);
    add_beat(REQ_READ, 7'd0, 32'sd0, 1'b0);

    // random traffic, every field randomized whatever the request
    for (int k = 0; k < RANDOM_BEATS; k++) begin
      r = $urandom_range(0, 99);
      add_beat(r < 34 ? REQ_PUSH  : r < 62 ? REQ_SCAN : r < 70 ? REQ_POP  :
               r < 78 ? REQ_LOAD  : r < 84 ? REQ_READ : r < 88 ? REQ_ERROR :
               r < 93 ? REQ_CLEAR : REQ_NOP,
               pick_symbol(), pick_load_value(), k == 0 || k == RANDOM_BEATS / 2);
    end
    beats_total = req_q.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (beats_sent < beats_total) @(posedge clk);
    while (display_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
